>>> src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache
// Word formats, command codes, sequencer states and the write controls
// that pass between the sequencer and the slot store.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES_DEFAULT    = 16;
  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int KEY_W              = 64;
  localparam int VALUE_W            = 32;
  localparam int CAP_W              = 5;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } lfu_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } lfu_state_t;

  typedef struct packed {
    lfu_cmd_t           command;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lfu_item_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value_out;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } lfu_result_t;

  typedef struct packed {
    logic key_we;
    logic value_we;
    logic count_we;
    logic set_valid;
    logic clear_valid;
  } lfu_wr_ctl_t;

  typedef struct packed {
    logic match_found;
    logic victim_found;
    logic free_found;
  } lfu_scan_flags_t;

endpackage

>>> src/lfu_slot_store.sv
// ----------------------------------------------------------------------------
// lfu_slot_store: slot storage of the LFU cache
// Key, value and use-count memories with one registered read port and one
// write port each, plus a valid bit per slot that reset clears.
// ----------------------------------------------------------------------------
module lfu_slot_store
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
  localparam int IDX_W     = $clog2(ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic                  rd_valid,
  output logic [KEY_W-1:0]      rd_key,
  output logic [VALUE_W-1:0]    rd_value,
  output logic [COUNT_BITS-1:0] rd_count,
  input  lfu_wr_ctl_t           wr,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [IDX_W-1:0]      clr_addr,
  input  logic [KEY_W-1:0]      wr_key,
  input  logic [VALUE_W-1:0]    wr_value,
  input  logic [COUNT_BITS-1:0] wr_count
);

  logic [KEY_W-1:0]      key_mem   [ENTRIES];
  logic [VALUE_W-1:0]    value_mem [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [ENTRIES-1:0]    valid_next;

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr.value_we) begin
      value_mem[wr_addr] <= wr_value;
    end
    if (wr.count_we) begin
      count_mem[wr_addr] <= wr_count;
    end
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // When the cleared slot is also the written slot, the set wins.
  always_comb begin
    valid_next = valid;
    if (wr.clear_valid) begin
      valid_next[clr_addr] = 1'b0;
    end
    if (wr.set_valid) begin
      valid_next[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

>>> src/lfu_scan.sv
// ----------------------------------------------------------------------------
// lfu_scan: per-slot compare unit of the LFU cache
// Takes one slot a cycle and accumulates the first key match, the valid
// slot with the smallest count, the first free slot and the occupancy.
// ----------------------------------------------------------------------------
module lfu_scan
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
  localparam int IDX_W     = $clog2(ENTRIES),
  localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  en,
  input  logic [IDX_W-1:0]      idx,
  input  logic [KEY_W-1:0]      query_key,
  input  logic                  slot_valid,
  input  logic [KEY_W-1:0]      slot_key,
  input  logic [VALUE_W-1:0]    slot_value,
  input  logic [COUNT_BITS-1:0] slot_count,
  output lfu_scan_flags_t       flags,
  output logic [IDX_W-1:0]      match_idx,
  output logic [VALUE_W-1:0]    match_value,
  output logic [COUNT_BITS-1:0] match_count,
  output logic [IDX_W-1:0]      victim_idx,
  output logic [KEY_W-1:0]      victim_key,
  output logic [IDX_W-1:0]      free_idx,
  output logic [CNT_W-1:0]      used
);

  logic [COUNT_BITS-1:0] victim_count;
  logic                  take_match;
  logic                  take_victim;
  logic                  take_free;

  always_comb begin
    take_match  = en && slot_valid && !flags.match_found && (slot_key == query_key);
    take_victim = en && slot_valid &&
                  (!flags.victim_found || (slot_count < victim_count));
    take_free   = en && !slot_valid && !flags.free_found;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
      used  <= '0;
    end else begin
      if (take_match) begin
        flags.match_found <= 1'b1;
      end
      if (take_victim) begin
        flags.victim_found <= 1'b1;
      end
      if (take_free) begin
        flags.free_found <= 1'b1;
      end
      if (en && slot_valid) begin
        used <= used + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      match_idx   <= idx;
      match_value <= slot_value;
      match_count <= slot_count;
    end
    if (take_victim) begin
      victim_idx   <= idx;
      victim_key   <= slot_key;
      victim_count <= slot_count;
    end
    if (take_free) begin
      free_idx <= idx;
    end
  end

endmodule

>>> src/lfu_cache_policy.sv
// ----------------------------------------------------------------------------
// lfu_cache_policy: fully associative least-frequently-used key/value cache
//
// A command word (lookup or insert, key, value) is taken at a clock edge
// with start high and busy low. busy then stays high until the result has
// been delivered. The sequencer reads one slot a cycle from the slot store
// and feeds it to the shared compare unit, which finds the key match, the
// least used valid slot and the first free slot. A drain state follows
// the last read, then an update state writes the slot back and registers
// the result word. done is high for exactly one cycle with the result on
// result; the receiver cannot stall, so the word must be taken then.
// busy falls with done, so the next item may be accepted at the edge that
// ends the done cycle, and not before.
// Reset clears all valid bits at once and sets capacity to 10. capacity is
// written through cfg_we and cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce. 0 acts as 1
// and values above ENTRIES act as ENTRIES.
// ----------------------------------------------------------------------------
module lfu_cache_policy
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lfu_item_t        item,
  output logic             done,
  output lfu_result_t      result,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  lfu_state_t            state;
  lfu_state_t            state_next;
  logic [CAP_W-1:0]      capacity;
  lfu_item_t             cur;
  logic [IDX_W-1:0]      scan_idx;
  logic                  proc_valid;
  logic [IDX_W-1:0]      proc_idx;
  logic                  accept;
  logic                  scan_last;
  logic                  rd_en;

  logic                  rd_valid;
  logic [KEY_W-1:0]      rd_key;
  logic [VALUE_W-1:0]    rd_value;
  logic [COUNT_BITS-1:0] rd_count;

  lfu_scan_flags_t       flags;
  logic [IDX_W-1:0]      match_idx;
  logic [VALUE_W-1:0]    match_value;
  logic [COUNT_BITS-1:0] match_count;
  logic [IDX_W-1:0]      victim_idx;
  logic [KEY_W-1:0]      victim_key;
  logic [IDX_W-1:0]      free_idx;
  logic [CNT_W-1:0]      used;

  lfu_wr_ctl_t           wr;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_count;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      eff_cap;
  logic                  evict;
  lfu_result_t           result_next;

  assign accept    = start && !busy;
  assign scan_last = (scan_idx == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      proc_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      proc_valid <= (state == ST_SCAN);
      done       <= (state == ST_UPDATE);
      if (accept) begin
        scan_idx <= '0;
      end else if (state == ST_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    proc_idx <= scan_idx;
    if (state == ST_UPDATE) begin
      result <= result_next;
    end
  end

  // Capacity clamped into the range 1 to ENTRIES.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    evict = (cur.command == CMD_INSERT) && !flags.match_found && flags.victim_found &&
            (CMP_W'(used) >= eff_cap);
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    rd_en       = (state == ST_SCAN);
    wr          = '0;
    wr_addr     = match_idx;
    wr_count    = COUNT_BITS'(1);
    result_next = '0;
    if (state == ST_UPDATE) begin
      case (cur.command)
        CMD_LOOKUP: begin
          if (flags.match_found) begin
            result_next.hit       = 1'b1;
            result_next.value_out = match_value;
            wr.count_we           = 1'b1;
            if (match_count != {COUNT_BITS{1'b1}}) begin
              wr_count = match_count + COUNT_BITS'(1);
            end else begin
              wr_count = match_count;
            end
          end
        end
        CMD_INSERT: begin
          if (flags.match_found) begin
            result_next.hit = 1'b1;
            wr.value_we     = 1'b1;
            wr.count_we     = 1'b1;
          end else begin
            // The evicted slot frees up; the lower of it and the first
            // empty slot takes the new entry.
            if (evict) begin
              result_next.evicted     = 1'b1;
              result_next.evicted_key = victim_key;
              wr.clear_valid          = 1'b1;
              if (flags.free_found && (free_idx < victim_idx)) begin
                wr_addr = free_idx;
              end else begin
                wr_addr = victim_idx;
              end
            end else begin
              wr_addr = free_idx;
            end
            if (evict || flags.free_found) begin
              wr.key_we    = 1'b1;
              wr.value_we  = 1'b1;
              wr.count_we  = 1'b1;
              wr.set_valid = 1'b1;
            end
          end
        end
        default: begin
          wr = '0;
        end
      endcase
    end
  end

  lfu_slot_store #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (scan_idx),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .rd_count (rd_count),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .clr_addr (victim_idx),
    .wr_key   (cur.key),
    .wr_value (cur.value),
    .wr_count (wr_count)
  );

  lfu_scan #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (accept),
    .en          (proc_valid),
    .idx         (proc_idx),
    .query_key   (cur.key),
    .slot_valid  (rd_valid),
    .slot_key    (rd_key),
    .slot_value  (rd_value),
    .slot_count  (rd_count),
    .flags       (flags),
    .match_idx   (match_idx),
    .match_value (match_value),
    .match_count (match_count),
    .victim_idx  (victim_idx),
    .victim_key  (victim_key),
    .free_idx    (free_idx),
    .used        (used)
  );

endmodule
